[hdl/lsi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsi_pkg: shared types and constants
// Sizes, command and status codes, and cell control for the indexed stack.
// ----------------------------------------------------------------------------
package lsi_pkg;

    localparam int DEPTH  = 16;
    localparam int WORD_W = 32;
    localparam int POS_W  = 5;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W  = (FILL_W > POS_W) ? FILL_W : POS_W;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [POS_W-1:0]         t_pos;
    typedef logic [FILL_W-1:0]        t_fill;
    typedef logic [IDX_W-1:0]         t_idx;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_INSERT = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    // broadcast to every cell: write word at slot, cells above move up
    typedef struct packed {
        logic  en;
        t_idx  slot;
        t_word word;
    } t_ins_ctl;

endpackage

[hdl/lsi_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsi_if: request and result channels
// Valid/ready channels carrying stack commands and their results.
// ----------------------------------------------------------------------------
interface lsi_cmd_if import lsi_pkg::*; ();
    logic  valid;
    logic  ready;
    t_cmd  command;
    t_word value;
    t_pos  position;

    modport source (output valid, command, value, position, input ready);
    modport sink   (input valid, command, value, position, output ready);
endinterface

interface lsi_res_if import lsi_pkg::*; ();
    logic    valid;
    logic    ready;
    t_word   read_value;
    t_fill   count;
    logic    not_empty;
    t_status status;

    modport source (output valid, read_value, count, not_empty, status, input ready);
    modport sink   (input valid, read_value, count, not_empty, status, output ready);
endinterface

[hdl/lifo_stack_indexed_insert.sv]
`timescale 1ns / 1ps
// A result is registered and presented in the cycle after its request is accepted.
// One request per cycle is taken; the result register frees as it is taken,
//   so the only stall comes from a result sink that holds ready low.
// Reset clears the entry count and the result valid flag; entry cells are
//   not cleared, as only entries below the count are ever read.
// ----------------------------------------------------------------------------
// lifo_stack_indexed_insert: bounded stack with indexed peek and insert
// Push, pop, peek by position and insert before position on a row of cells.
// ----------------------------------------------------------------------------
module lifo_stack_indexed_insert import lsi_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lsi_cmd_if.sink    i_cmd,
    lsi_res_if.source  o_res
);

    // -- control state
    t_fill r_fill;
    t_fill n_fill;
    logic  r_out_valid;

    // -- result register (payload, no reset needed)
    t_word   r_read_value;
    t_fill   r_count;
    t_status r_status;

    // -- per-request decode
    logic     w_accept;
    logic     w_full;
    logic     w_pos_above;     // position beyond the current count
    t_ins_ctl w_ins;
    t_idx     w_rd_idx;
    t_word    w_rd_word;
    t_word    w_read_value;
    t_status  w_status;
    t_pos     w_pos_m1;

    // Request taken whenever the result register is empty or being emptied.
    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign w_full      = (r_fill == FILL_W'(DEPTH));
    assign w_pos_above = (CMP_W'(i_cmd.position) > CMP_W'(r_fill));
    assign w_pos_m1    = i_cmd.position - POS_W'(1);
    assign w_rd_idx    = IDX_W'(w_pos_m1);

    // Command decode: status, new count and the insert broadcast.
    // Push is an insert at the top slot; pop only drops the count.
    always_comb begin
        n_fill       = r_fill;
        w_status     = ST_OK;
        w_read_value = '0;
        w_ins.en     = 1'b0;
        w_ins.slot   = IDX_W'(r_fill);
        w_ins.word   = i_cmd.value;
        case (i_cmd.command)
            CMD_PUSH: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins.en = 1'b1;
                    n_fill   = r_fill + FILL_W'(1);
                end
            end
            CMD_POP: begin
                if (r_fill == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_fill = r_fill - FILL_W'(1);
                end
            end
            CMD_PEEK: begin
                if (i_cmd.position == '0 || w_pos_above) begin
                    w_status = ST_BADPOS;
                end else begin
                    w_read_value = w_rd_word;
                end
            end
            CMD_INSERT: begin
                // full check takes precedence over the position check
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_pos_above) begin
                    w_status = ST_BADPOS;
                end else begin
                    w_ins.en   = 1'b1;
                    w_ins.slot = IDX_W'(i_cmd.position);
                    n_fill     = r_fill + FILL_W'(1);
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
        // cells only move on an accepted request
        if (!w_accept) begin
            w_ins.en = 1'b0;
        end
    end

    lsi_chain u_chain (
        .i_clk     (i_clk),
        .i_ins     (w_ins),
        .i_rd_idx  (w_rd_idx),
        .o_rd_word (w_rd_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_value <= w_read_value;
            r_count      <= n_fill;
            r_status     <= w_status;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.read_value = r_read_value;
    assign o_res.count      = r_count;
    assign o_res.not_empty  = (r_count != '0);
    assign o_res.status     = r_status;

endmodule

[hdl/lsi_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsi_cell: one stack entry
// Loads the new word at the insert slot, takes its lower neighbour above it.
// ----------------------------------------------------------------------------
module lsi_cell import lsi_pkg::*; (
    input  logic     i_clk,
    input  t_idx     i_index,
    input  t_ins_ctl i_ins,
    input  t_word    i_left,
    output t_word    o_word
);

    t_word r_word;
    t_word n_word;

    always_comb begin
        n_word = r_word;
        if (i_ins.en) begin
            if (i_index == i_ins.slot) begin
                n_word = i_ins.word;
            end else if (i_index > i_ins.slot) begin
                n_word = i_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

[hdl/lsi_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsi_chain: row of entry cells
// Each cell hands its word to the next on insert; read port picks one cell.
// ----------------------------------------------------------------------------
module lsi_chain import lsi_pkg::*; (
    input  logic     i_clk,
    input  t_ins_ctl i_ins,
    input  t_idx     i_rd_idx,
    output t_word    o_rd_word
);

    t_word w_cell [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_word w_left;
        if (k == 0) begin : g_bottom
            assign w_left = i_ins.word;
        end else begin : g_upper
            assign w_left = w_cell[k-1];
        end

        lsi_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(k)),
            .i_ins   (i_ins),
            .i_left  (w_left),
            .o_word  (w_cell[k])
        );
    end

    assign o_rd_word = w_cell[i_rd_idx];

endmodule

[test/lsi_result_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsi_result_check: stack result predictor and comparator
// Watches both channels, keeps its own copy of the stack, predicts the result
// of every accepted request and compares it with the result taken.
// ----------------------------------------------------------------------------
module lsi_result_check import lsi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    lsi_cmd_if   i_cmd,
    lsi_res_if   i_res,
    output int   o_fail_count,
    output int   o_outstanding
);

    localparam int REPORT_MAX = 10;

    typedef struct {
        t_word   read_value;
        t_fill   count;
        logic    not_empty;
        t_status status;
    } t_outcome;

    t_word    cells [DEPTH];
    int       level;
    t_outcome results_due [$];
    int       mismatches;

    // open a gap at slot and write word there; entries at or above move up
    function automatic void place_word(input int slot, input t_word word);
        for (int k = level; k > slot; k--) begin
            cells[k] = cells[k-1];
        end
        cells[slot] = word;
        level++;
    endfunction

    function automatic t_outcome apply_command(input t_cmd op, input t_word word,
                                               input t_pos pos);
        t_outcome r;
        r.read_value = '0;
        r.status     = ST_OK;
        case (op)
            CMD_PUSH: begin
                if (level >= DEPTH) r.status = ST_FULL;
                else                place_word(level, word);
            end
            CMD_POP: begin
                if (level == 0) r.status = ST_EMPTY;
                else            level--;
            end
            CMD_PEEK: begin
                if (pos == 0 || int'(pos) > level) r.status = ST_BADPOS;
                else                               r.read_value = cells[pos-1];
            end
            default: begin
                // full is checked ahead of position
                if (level >= DEPTH)           r.status = ST_FULL;
                else if (int'(pos) > level)   r.status = ST_BADPOS;
                else                          place_word(int'(pos), word);
            end
        endcase
        r.count     = t_fill'(level);
        r.not_empty = (level > 0);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            level = 0;
            results_due.delete();
        end else begin
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) begin
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: result with no request waiting: val=%0d cnt=%0d",
                                 $realtime, i_res.read_value, i_res.count);
                end else begin
                    want = results_due.pop_front();
                    if (i_res.read_value !== want.read_value || i_res.count !== want.count
                        || i_res.not_empty !== want.not_empty
                        || i_res.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $write("%0t: mismatch exp val=%0d cnt=%0d ne=%0b st=%0d",
                                   $realtime, want.read_value, want.count,
                                   want.not_empty, want.status);
                            $display(" got val=%0d cnt=%0d ne=%0b st=%0d",
                                     i_res.read_value, i_res.count, i_res.not_empty,
                                     i_res.status);
                        end
                    end
                end
            end
            if (i_cmd.valid === 1'b1 && i_cmd.ready === 1'b1)
                results_due.push_back(apply_command(i_cmd.command, i_cmd.value,
                                                    i_cmd.position));
        end
        o_fail_count  <= mismatches;
        o_outstanding <= results_due.size();
    end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top level of the indexed stack testbench
// Drives directed then random requests into the stack, stalls both sides in
// bursts, and reports the verdict from the result checker's failure count.
// ----------------------------------------------------------------------------
module tb;
    import lsi_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int QUIET_TAIL   = 200;  // requests at the end with no idling
    localparam int HOLD_AT      = 300;  // request count that triggers the long stall
    localparam int HOLD_CYCLES  = 80;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lsi_cmd_if cmd_ch ();
    lsi_res_if res_ch ();

    int fail_total;
    int outstanding;

    int issued;       // requests accepted so far
    int stack_level;  // entries held, tracked only to steer positions
    int total_items;
    int idle_pct;
    bit quiet;

    always #1 i_clk = ~i_clk;

    lifo_stack_indexed_insert dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    lsi_result_check u_result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd_ch),
        .i_res         (res_ch),
        .o_fail_count  (fail_total),
        .o_outstanding (outstanding)
    );

    // One request: optional idle burst, then hold valid until it is taken.
    // Valid is lowered and raised on different edges, never on the same one.
    task automatic issue(input t_cmd op, input t_word word, input int pos);
        if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.command  <= op;
        cmd_ch.value    <= word;
        cmd_ch.position <= t_pos'(pos);
        @(posedge i_clk);
        while (cmd_ch.ready !== 1'b1) @(posedge i_clk);
        // level changes on push, pop and insert only when they succeed
        case (op)
            CMD_PUSH:   if (stack_level < DEPTH) stack_level++;
            CMD_POP:    if (stack_level > 0) stack_level--;
            CMD_INSERT: if (stack_level < DEPTH && pos <= stack_level) stack_level++;
            default:    ;
        endcase
        issued++;
        quiet = (issued >= total_items - QUIET_TAIL);
    endtask

    function automatic t_word pick_word();
        case ($urandom_range(0, 11))
            0:       return t_word'(32'h8000_0000);
            1:       return t_word'(32'h7FFF_FFFF);
            2:       return '0;
            3:       return '1;
            default: return t_word'($urandom);
        endcase
    endfunction

    // Stimulus: reset, directed corner cases, then random requests whose mix
    // swings between filling and draining so both empty and full are reached.
    initial begin
        int   roll;
        int   pos;
        bit   filling;
        t_cmd op;

        issued      = 0;
        stack_level = 0;
        idle_pct    = 0;
        quiet       = 1'b0;
        total_items = 32 + RANDOM_ITEMS;

        i_rst_n         <= 1'b0;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.command  <= CMD_PUSH;
        cmd_ch.value    <= '0;
        cmd_ch.position <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty stack: pop, peeks and an out-of-range insert all refused
        issue(CMD_POP,    '0, 0);
        issue(CMD_PEEK,   '0, 0);
        issue(CMD_PEEK,   '0, 1);
        issue(CMD_INSERT, t_word'(7), 1);
        // insert at slot 0 on empty, then word extremes
        issue(CMD_INSERT, t_word'(32'h8000_0000), 0);
        issue(CMD_PUSH,   t_word'(32'h7FFF_FFFF), 0);
        issue(CMD_PUSH,   '0, 0);
        issue(CMD_PUSH,   '1, 0);
        // mid and bottom inserts shift the entries above
        issue(CMD_INSERT, t_word'(32'h5555_5555), 2);
        issue(CMD_INSERT, t_word'(32'hAAAA_AAAA), 0);
        issue(CMD_PEEK,   '0, 0);
        issue(CMD_PEEK,   '0, 1);
        issue(CMD_PEEK,   '0, 6);
        issue(CMD_PEEK,   '0, 7);
        issue(CMD_INSERT, t_word'(1), 7);
        // insert at slot equal to count acts as push
        issue(CMD_INSERT, t_word'(32'h1234_5678), 6);
        issue(CMD_POP,    '0, 0);
        while (stack_level < DEPTH) issue(CMD_PUSH, pick_word(), 0);
        // full: push and inserts refused, also at in-range positions
        issue(CMD_PUSH,   t_word'(3), 0);
        issue(CMD_INSERT, t_word'(4), 3);
        issue(CMD_INSERT, t_word'(5), 16);
        issue(CMD_PEEK,   '0, 16);

        filling = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    default: idle_pct = 35;
                endcase
            end
            if (stack_level == DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
            if (stack_level == 0 && $urandom_range(0, 3) == 0)     filling = 1'b1;
            if ($urandom_range(0, 39) == 0)                        filling = ~filling;

            roll = $urandom_range(0, 99);
            if (filling)
                op = (roll < 35) ? CMD_PUSH : (roll < 65) ? CMD_INSERT :
                     (roll < 75) ? CMD_POP  : CMD_PEEK;
            else
                op = (roll < 10) ? CMD_PUSH : (roll < 20) ? CMD_INSERT :
                     (roll < 65) ? CMD_POP  : CMD_PEEK;

            // positions mostly in range, some anywhere from 0 to 16
            if ($urandom_range(0, 9) == 0)
                pos = $urandom_range(0, 16);
            else if (op == CMD_PEEK)
                pos = (stack_level > 0) ? $urandom_range(1, stack_level) : 0;
            else
                pos = $urandom_range(0, stack_level);

            issue(op, pick_word(), pos);
        end
        cmd_ch.valid <= 1'b0;

        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_total == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Result side: random stall bursts, one long hold-off so the result
    // register fills and the request side stalls, no stalls in the tail.
    initial begin
        int stall_pct;
        int cyc;
        bit held;

        stall_pct    = 0;
        cyc          = 0;
        held         = 1'b0;
        res_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        res_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 200 == 0) begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 5;
                    default: stall_pct = 20;
                endcase
            end
            if (!held && issued >= HOLD_AT) begin
                held = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                res_ch.ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                res_ch.ready <= 1'b1;
            end
        end
    end

    // guard against a hung handshake
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
